// ===== design/rar_pkg.sv =====
package rar_pkg;

  // Fixed field widths of the item channels
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned NUM_W   = 32;
  localparam int unsigned DEN_W   = 31;
  localparam int unsigned RNUM_W  = 64;
  localparam int unsigned RDEN_W  = 62;
  localparam int unsigned WHOLE_W = 63;
  localparam int unsigned REM_W   = 62;

  // Operation codes
  typedef enum logic [REQ_W-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

endpackage

// ===== design/rar_if.sv =====
// Request channel: two fractions and an operation
interface rar_in_if;
  logic                           valid;
  logic                           ready;
  rar_pkg::op_t                   req_type;
  logic signed [rar_pkg::NUM_W-1:0] a_num;
  logic [rar_pkg::DEN_W-1:0]      a_den;
  logic signed [rar_pkg::NUM_W-1:0] b_num;
  logic [rar_pkg::DEN_W-1:0]      b_den;

  modport source (output valid, req_type, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, req_type, a_num, a_den, b_num, b_den, output ready);
endinterface

// Result channel: reduced fraction and mixed-number split
interface rar_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rar_pkg::RNUM_W-1:0] res_num;
  logic [rar_pkg::RDEN_W-1:0]        res_den;
  logic                              is_inf;
  logic [rar_pkg::WHOLE_W-1:0]       whole_part;
  logic [rar_pkg::REM_W-1:0]         frac_rem;

  modport source (output valid, res_num, res_den, is_inf, whole_part, frac_rem, input ready);
  modport sink   (input valid, res_num, res_den, is_inf, whole_part, frac_rem, output ready);
endinterface

// ===== design/rational_arith_reduce_core.sv =====
// Steps: capture, three multiplies, combine, binary gcd, three restoring divisions
//   (nm/g, dm/g, nm/dm), then output; zero or infinite results skip gcd and divisions.
// Throughput: one item at a time; din.ready is high only while the sequencer idles.
// A finished item waits in the output register while the next one is taken.
// Shared units: one (W+1)x(W+1) multiplier, one gcd subtractor, one 1-bit/cycle divider.
// Reset (synchronous, rst high) returns the sequencer to idle and drops dout.valid.
module rational_arith_reduce_core #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  rar_in_if.sink     din,
  rar_out_if.source  dout
);

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned OW = W + 1;          // operand width with sign
  localparam int unsigned SW = 2 * W + 2;      // signed product width
  localparam int unsigned MW = 2 * W - 1;      // magnitude width
  localparam int unsigned KW = $clog2(MW);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_SUM  = 7'b0000100,
    S_GCD  = 7'b0001000,
    S_DLD  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state;

  rar_pkg::op_t          op;
  logic signed [OW-1:0]  an, ad, bn, bd;
  logic [1:0]            mcnt;
  logic signed [SW-1:0]  p0, p1, p2;
  logic                  neg;
  logic [MW-1:0]         nm, dm;
  logic [MW-1:0]         u, v;
  logic [KW-1:0]         k;
  logic [1:0]            phase;
  logic [MW-1:0]         dq, dd, dr;
  logic [KW-1:0]         dcnt;

  // Combine results of the products
  logic signed [SW-1:0]  num_c, den_c, nabs, dabs;
  logic [MW-1:0]         whole_r, rem_r;
  logic                  inf_r, zero_r;

  // Shared multiplier operand selection
  logic signed [OW-1:0]  ma, mb;
  logic signed [SW-1:0]  prod;

  always_comb begin
    unique case (mcnt)
      2'd0:    begin ma = an; mb = (op == rar_pkg::OP_MUL) ? bn : bd; end
      2'd1:    begin ma = ad; mb = (op == rar_pkg::OP_MUL) ? bd : bn; end
      default: begin ma = ad; mb = bd; end
    endcase
  end
  assign prod = ma * mb;

  always_comb begin
    num_c = p0;
    den_c = p1;
    unique case (op)
      rar_pkg::OP_ADD: begin num_c = p0 + p1; den_c = p2; end
      rar_pkg::OP_SUB: begin num_c = p0 - p1; den_c = p2; end
      rar_pkg::OP_MUL: begin num_c = p0;      den_c = p1; end
      default: begin
        if (bn == '0) begin
          num_c = '0; den_c = '0;
        end
      end
    endcase
    nabs = num_c[SW-1] ? -num_c : num_c;
    dabs = den_c[SW-1] ? -den_c : den_c;
  end

  // Divider step: shift in next dividend bit, subtract if it fits
  logic [MW:0] dt;
  logic        dfit;
  assign dt   = {dr, dq[MW-1]};
  assign dfit = dt >= {1'b0, dd};

  assign din.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      dout.valid <= 1'b0;
    end else begin
      if (dout.valid && dout.ready && state != S_OUT) dout.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (din.valid) begin
            op    <= din.req_type;
            an    <= OW'($signed(din.a_num[W-1:0]));
            bn    <= OW'($signed(din.b_num[W-1:0]));
            ad    <= $signed({2'b00, din.a_den[W-2:0]});
            bd    <= $signed({2'b00, din.b_den[W-2:0]});
            mcnt  <= 2'd0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          unique case (mcnt)
            2'd0:    p0 <= prod;
            2'd1:    p1 <= prod;
            default: p2 <= prod;
          endcase
          mcnt <= mcnt + 2'd1;
          if (mcnt == 2'd2) state <= S_SUM;
        end
        S_SUM: begin
          inf_r  <= (den_c == '0);
          zero_r <= (num_c == '0);
          neg    <= num_c[SW-1] ^ den_c[SW-1];
          nm     <= MW'(nabs);
          dm     <= MW'(dabs);
          u      <= MW'(nabs);
          v      <= MW'(dabs);
          k      <= '0;
          phase  <= 2'd0;
          if (den_c == '0 || num_c == '0) state <= S_OUT;
          else state <= S_GCD;
        end
        // Binary gcd, one shift or subtract a cycle
        S_GCD: begin
          priority if (u == '0) begin
            v     <= v << k;
            state <= S_DLD;
          end else if (!u[0] && !v[0]) begin
            u <= u >> 1; v <= v >> 1; k <= k + 1'b1;
          end else if (!u[0]) begin
            u <= u >> 1;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (u >= v) begin
            u <= (u - v) >> 1;
          end else begin
            v <= (v - u) >> 1;
          end
        end
        // Load divider: nm/g, dm/g, then nm/dm
        S_DLD: begin
          unique case (phase)
            2'd0:    begin dq <= nm; dd <= v;  end
            2'd1:    begin dq <= dm; dd <= v;  end
            default: begin dq <= nm; dd <= dm; end
          endcase
          dr    <= '0;
          dcnt  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          dq   <= {dq[MW-2:0], dfit};
          dr   <= dfit ? MW'(dt - {1'b0, dd}) : dt[MW-1:0];
          dcnt <= dcnt + 1'b1;
          if (dcnt == KW'(MW - 1)) begin
            phase <= phase + 2'd1;
            unique case (phase)
              2'd0:    begin nm <= {dq[MW-2:0], dfit}; state <= S_DLD; end
              2'd1:    begin dm <= {dq[MW-2:0], dfit}; state <= S_DLD; end
              default: begin
                whole_r <= {dq[MW-2:0], dfit};
                rem_r   <= dfit ? MW'(dt - {1'b0, dd}) : dt[MW-1:0];
                state   <= S_OUT;
              end
            endcase
          end
        end
        // Hand over once the output register is free
        S_OUT: begin
          if (!dout.valid || dout.ready) begin
            dout.valid <= 1'b1;
            priority if (inf_r) begin
              dout.res_num    <= '0;
              dout.res_den    <= '0;
              dout.is_inf     <= 1'b1;
              dout.whole_part <= '0;
              dout.frac_rem   <= '0;
            end else if (zero_r) begin
              dout.res_num    <= '0;
              dout.res_den    <= rar_pkg::RDEN_W'(1);
              dout.is_inf     <= 1'b0;
              dout.whole_part <= '0;
              dout.frac_rem   <= '0;
            end else begin
              dout.res_num    <= neg ? -$signed(rar_pkg::RNUM_W'(nm))
                                     :  $signed(rar_pkg::RNUM_W'(nm));
              dout.res_den    <= rar_pkg::RDEN_W'(dm);
              dout.is_inf     <= 1'b0;
              dout.whole_part <= rar_pkg::WHOLE_W'(whole_r);
              dout.frac_rem   <= rar_pkg::REM_W'(rem_r);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    din.valid && din.ready |=> !din.ready)
    else $error("ready while an item is in work");

  a_inf_zero: assert property (@(posedge clk) disable iff (rst)
    dout.valid && dout.is_inf |-> dout.res_num == '0 && dout.res_den == '0)
    else $error("infinite result with nonzero fields");

  a_finite_den: assert property (@(posedge clk) disable iff (rst)
    dout.valid && !dout.is_inf |-> dout.res_den != '0)
    else $error("finite result with zero denominator");

  a_gcd_v_live: assert property (@(posedge clk) disable iff (rst)
    state == S_GCD |-> v != '0)
    else $error("gcd operand lost");

endmodule
